### sv/gti_pkg.sv
// constants and types for the grid trilinear interpolator
// no dependencies
package gti_pkg;
  localparam int MAX_POINTS = 32;
  localparam int VALUE_W    = 24;
  localparam int POS_W      = 24;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int ADDR_W     = 3 * IDX_W;
  localparam int DEPTH      = MAX_POINTS * MAX_POINTS * MAX_POINTS;
  localparam int NP_W       = 6;
  localparam int HE_W       = 23;
  localparam int SCALE_W    = 24;
  localparam int FRAC_BITS  = 28;
  localparam int P_W        = POS_W + 1;
  localparam int U_W        = P_W + SCALE_W + 1;
  localparam int IDXS_W     = U_W - FRAC_BITS + 1;
  localparam int F_W        = FRAC_BITS + 1;
  localparam int ACC_W      = 32;
  localparam int D_W        = ACC_W + 1;
  localparam int PROD_W     = D_W + F_W;
  localparam int CFG_W      = 24;

  localparam logic signed [D_W-1:0] PI_Q16     = D_W'(205887);
  localparam logic signed [D_W-1:0] TWO_PI_Q16 = D_W'(411775);

  typedef enum logic [1:0] {
    OP_WR_MAG = 2'd0,
    OP_WR_PH  = 2'd1,
    OP_RD_MAG = 2'd2,
    OP_RD_PH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_POINTS = 2'd0,
    REG_3D     = 2'd1,
    REG_HALF   = 2'd2,
    REG_SCALE  = 2'd3
  } cfg_reg_t;
endpackage

### sv/grid_trilinear_interpolator.sv
// grid trilinear interpolator: two sample grids in synchronous memories, one shared lerp unit
// depends on gti_pkg
// queries: map the position (S_ADD, S_MUL, S_SPLIT, S_CHK), read each corner, then run each lerp step
// (S_DIFF, S_PROD, S_RND) and register the result; off-lattice queries skip the reads and lerps
// throughput: writes every cycle while idle; a new word is accepted once a query result is registered
// reset (rst_n, synchronous): control and config to defaults; grids undefined until written
module grid_trilinear_interpolator import gti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [IDX_W-1:0]          in_entry_x,
  input  logic [IDX_W-1:0]          in_entry_y,
  input  logic [IDX_W-1:0]          in_entry_z,
  input  logic signed [VALUE_W-1:0] in_entry_value,
  input  logic signed [POS_W-1:0]   in_pos_x,
  input  logic signed [POS_W-1:0]   in_pos_y,
  input  logic signed [POS_W-1:0]   in_pos_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_interp_value,
  output logic                      out_off_grid
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ADD   = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_SPLIT = 10'b0000001000,
    S_CHK   = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_DIFF  = 10'b0001000000,
    S_PROD  = 10'b0010000000,
    S_RND   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [NP_W-1:0]    points_r;
  logic               three_d_r;
  logic [HE_W-1:0]    half_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r  <= NP_W'(1);
      three_d_r <= 1'b1;
      half_r    <= '0;
      scale_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINTS: points_r  <= cfg_wdata[NP_W-1:0];
        REG_3D:     three_d_r <= cfg_wdata[0];
        REG_HALF:   half_r    <= cfg_wdata[HE_W-1:0];
        REG_SCALE:  scale_r   <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // points in use, clamped to 1..MAX_POINTS
  logic [NP_W:0] np;
  always_comb begin
    if (points_r == '0) np = (NP_W+1)'(1);
    else if ({1'b0, points_r} > (NP_W+1)'(MAX_POINTS)) np = (NP_W+1)'(MAX_POINTS);
    else np = {1'b0, points_r};
  end

  logic in_acc, is_wr;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_wr    = (in_opcode == OP_WR_MAG) || (in_opcode == OP_WR_PH);

  // query context
  logic                    ph_r, td_r;
  logic signed [POS_W-1:0] pos_r [3];
  logic signed [P_W-1:0]   p_r   [3];
  logic signed [U_W-1:0]   u_r   [3];
  logic signed [IDXS_W-1:0] idx_r [3];
  logic signed [F_W-1:0]   frac_r [3];
  logic [IDX_W-1:0]        lo_r [3];
  logic [IDX_W-1:0]        hi_r [3];

  // memories: write at accept, registered read
  logic [ADDR_W-1:0]         wr_addr, rd_addr;
  logic                      we_mag, we_ph;
  logic signed [VALUE_W-1:0] mag_mem [DEPTH];
  logic signed [VALUE_W-1:0] ph_mem  [DEPTH];
  logic signed [VALUE_W-1:0] mag_q_r, ph_q_r;

  assign wr_addr = {in_entry_z, in_entry_y, in_entry_x};
  assign we_mag  = in_acc && (in_opcode == OP_WR_MAG);
  assign we_ph   = in_acc && (in_opcode == OP_WR_PH);

  always_ff @(posedge clk) begin
    if (we_mag) mag_mem[wr_addr] <= in_entry_value;
    mag_q_r <= mag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_ph) ph_mem[wr_addr] <= in_entry_value;
    ph_q_r <= ph_mem[rd_addr];
  end

  // corner fetch: bit0 picks upper y, bit1 upper x, bit2 upper z
  logic [3:0] rd_cnt_r;
  logic [3:0] n_corner;
  logic [2:0] csel;
  assign n_corner = td_r ? 4'd8 : 4'd4;
  assign csel     = rd_cnt_r[2:0];
  assign rd_addr  = {csel[2] ? hi_r[2] : lo_r[2],
                     csel[0] ? hi_r[1] : lo_r[1],
                     csel[1] ? hi_r[0] : lo_r[0]};

  logic signed [VALUE_W-1:0] corner_r [8];
  logic signed [VALUE_W-1:0] rd_data;
  assign rd_data = ph_r ? ph_q_r : mag_q_r;

  // shared lerp unit: diff/unwrap, multiply, round and add
  logic [2:0]               step_r;
  logic signed [ACC_W-1:0]  res_r [7];
  logic signed [ACC_W-1:0]  op_a, op_b;
  logic signed [F_W-1:0]    op_f;
  logic signed [D_W-1:0]    diff, diff_u1, diff_u2;
  logic signed [ACC_W-1:0]  a_r;
  logic signed [D_W-1:0]    d_r;
  logic signed [F_W-1:0]    f_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        prod_mag;
  logic [PROD_W-FRAC_BITS-1:0] rnd;
  logic signed [ACC_W:0]    lerp_out;

  always_comb begin
    case (step_r)
      3'd0: begin
        op_a = ACC_W'(corner_r[0]); op_b = ACC_W'(corner_r[1]); op_f = frac_r[1];
      end
      3'd1: begin
        op_a = ACC_W'(corner_r[2]); op_b = ACC_W'(corner_r[3]); op_f = frac_r[1];
      end
      3'd2: begin
        op_a = res_r[0]; op_b = res_r[1]; op_f = frac_r[0];
      end
      3'd3: begin
        op_a = ACC_W'(corner_r[4]); op_b = ACC_W'(corner_r[5]); op_f = frac_r[1];
      end
      3'd4: begin
        op_a = ACC_W'(corner_r[6]); op_b = ACC_W'(corner_r[7]); op_f = frac_r[1];
      end
      3'd5: begin
        op_a = res_r[3]; op_b = res_r[4]; op_f = frac_r[0];
      end
      default: begin
        op_a = res_r[2]; op_b = res_r[5]; op_f = frac_r[2];
      end
    endcase
  end

  // phase differences unwrap once beyond +-pi
  always_comb begin
    diff    = D_W'(op_b) - D_W'(op_a);
    diff_u1 = (ph_r && diff > PI_Q16) ? diff - TWO_PI_Q16 : diff;
    diff_u2 = (ph_r && diff_u1 < -PI_Q16) ? diff_u1 + TWO_PI_Q16 : diff_u1;
  end

  // round to nearest, ties away from zero
  always_comb begin
    prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    rnd      = (PROD_W-FRAC_BITS)'((prod_mag + (PROD_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS);
    lerp_out = prod_r[PROD_W-1] ? (ACC_W+1)'(a_r) - (ACC_W+1)'(rnd)
                                : (ACC_W+1)'(a_r) + (ACC_W+1)'(rnd);
  end

  logic last_step;
  assign last_step = (step_r == 3'd6) || (step_r == 3'd2 && !td_r);

  // saturation of the final value
  localparam logic signed [ACC_W-1:0] VMAX = ACC_W'((64'sd1 <<< (VALUE_W-1)) - 1);
  localparam logic signed [ACC_W-1:0] VMIN = -VMAX - ACC_W'(1);
  logic signed [ACC_W-1:0]   lerp_acc;
  logic signed [VALUE_W-1:0] sat_val;
  assign lerp_acc = lerp_out[ACC_W-1:0];
  always_comb begin
    if (lerp_acc > VMAX) sat_val = VALUE_W'(VMAX);
    else if (lerp_acc < VMIN) sat_val = VALUE_W'(VMIN);
    else sat_val = lerp_acc[VALUE_W-1:0];
  end

  // off-lattice test on mapped indices
  logic off_any;
  always_comb begin
    off_any = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (idx_r[k] < 0 || idx_r[k] > IDXS_W'($signed({1'b0, np}) - 1)) off_any = 1'b1;
    end
  end

  logic signed [VALUE_W-1:0] fin_val_r;
  logic                      fin_off_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_val_r;
  logic                      out_off_r;
  logic                      out_free;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && !is_wr) state_nxt = S_ADD;
      S_ADD:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SPLIT;
      S_SPLIT: state_nxt = S_CHK;
      S_CHK:   state_nxt = off_any ? S_DONE : S_READ;
      S_READ:  if (rd_cnt_r == n_corner) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_PROD;
      S_PROD:  state_nxt = S_RND;
      S_RND:   state_nxt = last_step ? S_DONE : S_DIFF;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      step_r   <= '0;
    end else begin
      if (state_r == S_CHK) rd_cnt_r <= '0;
      else if (state_r == S_READ) rd_cnt_r <= rd_cnt_r + 4'd1;
      if (state_r == S_CHK) step_r <= '0;
      else if (state_r == S_RND) step_r <= step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_wr) begin
      ph_r     <= (in_opcode == OP_RD_PH);
      td_r     <= three_d_r;
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
    end
    if (state_r == S_ADD) begin
      for (int k = 0; k < 3; k++) p_r[k] <= P_W'(pos_r[k]) + $signed(P_W'(half_r));
    end
    if (state_r == S_MUL) begin
      for (int k = 0; k < 3; k++) u_r[k] <= U_W'(p_r[k]) * $signed(U_W'(scale_r));
    end
    if (state_r == S_SPLIT) begin
      for (int k = 0; k < 3; k++) begin
        logic [U_W-1:0] um;
        um = u_r[k][U_W-1] ? U_W'(-u_r[k]) : U_W'(u_r[k]);
        if (k == 2 && !td_r) begin
          idx_r[k]  <= '0;
          frac_r[k] <= '0;
        end else if (u_r[k][U_W-1]) begin
          idx_r[k]  <= -$signed(IDXS_W'(um >> FRAC_BITS));
          frac_r[k] <= -$signed({1'b0, um[FRAC_BITS-1:0]});
        end else begin
          idx_r[k]  <= IDXS_W'(um >> FRAC_BITS);
          frac_r[k] <= $signed({1'b0, um[FRAC_BITS-1:0]});
        end
      end
    end
    if (state_r == S_CHK) begin
      // upper neighbor clamps at the last point in use
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= idx_r[k][IDX_W-1:0];
        if (idx_r[k] + IDXS_W'(1) < IDXS_W'(np)) hi_r[k] <= idx_r[k][IDX_W-1:0] + IDX_W'(1);
        else hi_r[k] <= IDX_W'(np - (NP_W+1)'(1));
      end
      fin_val_r <= '0;
      fin_off_r <= off_any;
    end
    if (state_r == S_READ && rd_cnt_r != 4'd0) corner_r[rd_cnt_r[2:0] - 3'd1] <= rd_data;
    if (state_r == S_DIFF) begin
      a_r <= op_a;
      d_r <= diff_u2;
      f_r <= op_f;
    end
    if (state_r == S_PROD) prod_r <= PROD_W'(d_r) * PROD_W'(f_r);
    if (state_r == S_RND) begin
      res_r[step_r] <= lerp_acc;
      if (last_step) fin_val_r <= sat_val;
    end
  end

  // output register, loaded when the sequencer is in S_DONE and the register is free
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_val_r <= fin_val_r;
      out_off_r <= fin_off_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_val_r;
  assign out_off_grid     = out_off_r;

`ifndef SYNTHESIS
  // grid writes only happen from idle
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (we_mag || we_ph) |-> state_r == S_IDLE)
    else $error("grid write outside idle");

  // corner fetch never runs past the last corner
  a_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> rd_cnt_r <= n_corner)
    else $error("corner counter overrun");

  // lerp schedule stays within seven steps
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIFF || state_r == S_RND) |-> step_r <= 3'd6)
    else $error("lerp step overrun");

  // a pending word is never overwritten while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_val_r) && $stable(out_off_r))
    else $error("output word overwritten");
`endif

endmodule
